[rtl/rmdn_pkg.sv]
package rmdn_pkg;

    typedef enum logic [1:0] {
        MODE_MUL_REDUCE = 2'd0,
        MODE_MUL_RAW    = 2'd1,
        MODE_DIV_REDUCE = 2'd2,
        MODE_REDUCE_A   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_DIVN_START,
        ST_DIVN_WAIT,
        ST_DIVD_START,
        ST_DIVD_WAIT,
        ST_OUT
    } state_t;

endpackage

[rtl/rmdn_if.sv]
interface rmdn_in_if #(parameter int WORD_BITS = 64);
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [WORD_BITS-1:0] a_num;
    logic [WORD_BITS-1:0] a_den;
    logic [WORD_BITS-1:0] b_num;
    logic [WORD_BITS-1:0] b_den;
    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rmdn_out_if #(parameter int WORD_BITS = 64);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] res_num;
    logic [WORD_BITS-1:0] res_den;
    logic                 undefined_flag;
    modport source (output valid, res_num, res_den, undefined_flag, input ready);
    modport sink (input valid, res_num, res_den, undefined_flag, output ready);
endinterface

[rtl/rmdn_mul.sv]
module rmdn_mul #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    output logic                 done,
    output logic [WORD_BITS-1:0] p
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] mc_reg, mc_next;
    logic [WORD_BITS-1:0] mp_reg, mp_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = x;
            mp_next   = y;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = {mc_reg[WORD_BITS-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[WORD_BITS-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WORD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule

[rtl/rmdn_div.sv]
module rmdn_div #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    output logic                 done,
    output logic [WORD_BITS-1:0] quo,
    output logic [WORD_BITS-1:0] rem
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] q_reg, q_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] d_reg, d_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[WORD_BITS-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = x;
            r_next    = '0;
            d_next    = y;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_BITS])
            begin
                r_next = trial[WORD_BITS-1:0];
                q_next = {q_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[WORD_BITS-2:0], q_reg[WORD_BITS-1]};
                q_next = {q_reg[WORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WORD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;
endmodule

[rtl/rmdn_gcd.sv]
module rmdn_gcd
    import rmdn_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    output logic                 done,
    output logic [WORD_BITS-1:0] g
);
    // Binary gcd: strip common twos, then subtract and shift, one step a cycle.
    localparam int KW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] u_reg, u_next;
    logic [WORD_BITS-1:0] v_reg, v_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [1:0]           ph_reg, ph_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS-1:0] g_reg, g_next;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TWOS = 2'd1;
    localparam logic [1:0] PH_LOOP = 2'd2;

    always_comb
    begin
        u_next    = u_reg;
        v_next    = v_reg;
        k_next    = k_reg;
        ph_next   = ph_reg;
        g_next    = g_reg;
        done_next = 1'b0;
        if (start)
        begin
            u_next  = x;
            v_next  = y;
            k_next  = '0;
            ph_next = PH_TWOS;
        end
        else
        begin
            case (ph_reg)
                PH_TWOS:
                begin
                    if (u_reg == '0 || v_reg == '0)
                    begin
                        g_next    = u_reg | v_reg;
                        done_next = 1'b1;
                        ph_next   = PH_IDLE;
                    end
                    else if (!u_reg[0] && !v_reg[0])
                    begin
                        u_next = u_reg >> 1;
                        v_next = v_reg >> 1;
                        k_next = k_reg + 1'b1;
                    end
                    else
                    begin
                        ph_next = PH_LOOP;
                    end
                end
                PH_LOOP:
                begin
                    if (u_reg == '0 || v_reg == '0)
                    begin
                        g_next    = (u_reg | v_reg) << k_reg;
                        done_next = 1'b1;
                        ph_next   = PH_IDLE;
                    end
                    else if (!u_reg[0])
                    begin
                        u_next = u_reg >> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_next = v_reg >> 1;
                    end
                    else if (u_reg >= v_reg)
                    begin
                        u_next = (u_reg - v_reg) >> 1;
                    end
                    else
                    begin
                        v_next = (v_reg - u_reg) >> 1;
                    end
                end
                default:
                begin
                    ph_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign done = done_reg;
    assign g    = g_reg;
endmodule

[rtl/rational_mul_div_normalize_top.sv]
// Rational multiply, divide and reduce on unsigned WORD_BITS-bit rationals.
// Input channel in_ch carries mode, a_num, a_den, b_num and b_den; a transfer
// happens when valid and ready are both high. Output channel out_ch carries
// res_num, res_den and undefined_flag, one result per input transfer.
// The block works on one item at a time and drops ready from the input
// transfer until its result has been taken.
// Steps: two shift-add multiplies (skipped in reduce-A mode), a binary gcd,
// then two restoring divisions; raw multiply mode ends after the multiplies.
// Both parts zero skip division and set undefined_flag. A stalled receiver
// holds the result in the output register and the block accepts nothing new.
// Reset clears the sequencer to idle with no result pending.
module rational_mul_div_normalize_top
    import rmdn_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input logic clk,
    input logic rst_n,
    rmdn_in_if.sink    in_ch,
    rmdn_out_if.source out_ch
);
    state_t               st_reg, st_next;
    mode_t                mode_reg, mode_next;
    logic [WORD_BITS-1:0] an_reg, an_next, ad_reg, ad_next;
    logic [WORD_BITS-1:0] bn_reg, bn_next, bd_reg, bd_next;
    logic [WORD_BITS-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic [WORD_BITS-1:0] g_reg, g_next;
    logic                 flag_reg, flag_next;

    logic                 mul_start, mul_done;
    logic [WORD_BITS-1:0] mul_x, mul_y, mul_p;
    logic                 gcd_start, gcd_done;
    logic [WORD_BITS-1:0] gcd_g;
    logic                 div_start, div_done;
    logic [WORD_BITS-1:0] div_x, div_q, div_r;

    rmdn_mul #(.WORD_BITS(WORD_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
        .done(mul_done), .p(mul_p)
    );

    rmdn_gcd #(.WORD_BITS(WORD_BITS)) u_gcd (
        .clk(clk), .rst_n(rst_n), .start(gcd_start), .x(rn_reg), .y(rd_reg),
        .done(gcd_done), .g(gcd_g)
    );

    rmdn_div #(.WORD_BITS(WORD_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .x(div_x), .y(g_reg),
        .done(div_done), .quo(div_q), .rem(div_r)
    );

    always_comb
    begin
        st_next   = st_reg;
        mode_next = mode_reg;
        an_next   = an_reg;
        ad_next   = ad_reg;
        bn_next   = bn_reg;
        bd_next   = bd_reg;
        rn_next   = rn_reg;
        rd_next   = rd_reg;
        g_next    = g_reg;
        flag_next = flag_reg;
        mul_start = 1'b0;
        gcd_start = 1'b0;
        div_start = 1'b0;
        mul_x     = an_reg;
        mul_y     = bn_reg;
        div_x     = rn_reg;
        in_ch.ready = (st_reg == ST_IDLE);
        case (st_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    mode_next = mode_t'(in_ch.mode);
                    an_next   = in_ch.a_num;
                    ad_next   = in_ch.a_den;
                    flag_next = 1'b0;
                    if (mode_t'(in_ch.mode) == MODE_DIV_REDUCE)
                    begin
                        bn_next = in_ch.b_den;
                        bd_next = in_ch.b_num;
                    end
                    else
                    begin
                        bn_next = in_ch.b_num;
                        bd_next = in_ch.b_den;
                    end
                    if (mode_t'(in_ch.mode) == MODE_REDUCE_A)
                    begin
                        rn_next = in_ch.a_num;
                        rd_next = in_ch.a_den;
                        st_next = ST_GCD_START;
                    end
                    else
                    begin
                        st_next = ST_MUL1;
                        mul_start = 1'b1;
                        mul_x = in_ch.a_num;
                        mul_y = (mode_t'(in_ch.mode) == MODE_DIV_REDUCE) ?
                                in_ch.b_den : in_ch.b_num;
                    end
                end
            end
            ST_MUL1:
            begin
                if (mul_done)
                begin
                    rn_next   = mul_p;
                    mul_start = 1'b1;
                    mul_x     = ad_reg;
                    mul_y     = bd_reg;
                    st_next   = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                mul_x = ad_reg;
                mul_y = bd_reg;
                if (mul_done)
                begin
                    rd_next = mul_p;
                    st_next = (mode_reg == MODE_MUL_RAW) ? ST_OUT : ST_GCD_START;
                end
            end
            ST_GCD_START:
            begin
                gcd_start = 1'b1;
                st_next   = ST_GCD_WAIT;
            end
            ST_GCD_WAIT:
            begin
                if (gcd_done)
                begin
                    g_next = gcd_g;
                    if (gcd_g == '0)
                    begin
                        flag_next = 1'b1;
                        st_next   = ST_OUT;
                    end
                    else
                    begin
                        st_next = ST_DIVN_START;
                    end
                end
            end
            ST_DIVN_START:
            begin
                div_start = 1'b1;
                st_next   = ST_DIVN_WAIT;
            end
            ST_DIVN_WAIT:
            begin
                if (div_done)
                begin
                    rn_next = div_q;
                    st_next = ST_DIVD_START;
                end
            end
            ST_DIVD_START:
            begin
                div_x     = rd_reg;
                div_start = 1'b1;
                st_next   = ST_DIVD_WAIT;
            end
            ST_DIVD_WAIT:
            begin
                if (div_done)
                begin
                    rd_next = div_q;
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        bn_reg   <= bn_next;
        bd_reg   <= bd_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        g_reg    <= g_next;
        flag_reg <= flag_next;
    end

    assign out_ch.valid          = (st_reg == ST_OUT);
    assign out_ch.res_num        = rn_reg;
    assign out_ch.res_den        = rd_reg;
    assign out_ch.undefined_flag = flag_reg;

    logic unused_rem;
    assign unused_rem = ^div_r;
endmodule
